### rtl/srmvp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes for the sparse row matrix multi-vector product core.
package srmvp_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_VECTORS = 8;
  localparam int NCELL       = (MAX_VECTORS < 8) ? MAX_VECTORS : 8;
  localparam int ADDR_W      = $clog2(MAX_ROWS);

  localparam int COL_W  = 10;
  localparam int VSEL_W = 3;
  localparam int VAL_W  = 32;
  localparam int ROW_W  = 10;
  localparam int SUM_W  = 64;
  localparam int RC_W   = 11;
  localparam int VC_W   = 4;
  localparam int CFG_W  = RC_W;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_FIELD_W = ROW_W + VSEL_W + SUM_W;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam int DRAIN_LAST = NCELL + 1;
  localparam int CNT_W      = $clog2(DRAIN_LAST + 1);

  typedef enum logic [0:0] {
    CFG_ROW_COUNT    = 1'b0,
    CFG_VECTOR_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    MODE_LOAD  = 1'b0,
    MODE_ENTRY = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_STREAM,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              valid;
    mode_e             mode;
    logic [COL_W-1:0]  column;
    logic [VSEL_W-1:0] sel;
    logic [VAL_W-1:0]  value;
  } tok_t;

  typedef struct packed {
    logic            clear;
    logic [VC_W-1:0] nv;
  } ctrl_t;

endpackage

### rtl/srmvp_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module srmvp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/srmvp_cell.sv
`timescale 1ns / 1ps
// One vector cell: element bank, multiply stage and saturating accumulator.
module srmvp_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [srmvp_pkg::VSEL_W-1:0]          cell_id_i,
  input  srmvp_pkg::ctrl_t                      ctrl_i,
  input  srmvp_pkg::tok_t                       tok_i,
  output srmvp_pkg::tok_t                       tok_o,
  output logic signed [srmvp_pkg::SUM_W-1:0]    acc_o
);
  import srmvp_pkg::*;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W-1:0] s;
    s = a + b;
    if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
      sat_add = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s;
    end
  endfunction

  tok_t                     tok_q;
  logic                     active;
  logic                     we;
  logic                     in_range;
  logic [VAL_W-1:0]         rdata;
  logic                     s1_valid_q;
  logic                     s1_zero_q;
  logic signed [VAL_W-1:0]  s1_value_q;
  logic signed [VAL_W-1:0]  element;
  logic                     p_valid_q;
  logic signed [SUM_W-1:0]  prod_q;
  logic signed [SUM_W-1:0]  acc_q;
  logic signed [SUM_W-1:0]  acc_d;

  assign active   = ({1'b0, cell_id_i} < ctrl_i.nv);
  assign we       = tok_q.valid && (tok_q.mode == MODE_LOAD) && (tok_q.sel == cell_id_i);
  assign in_range = ({{(32-COL_W){1'b0}}, tok_q.column} < 32'(MAX_ROWS));

  srmvp_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_ROWS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (tok_q.column[ADDR_W-1:0]),
    .wdata_i(tok_q.value),
    .rdata_o(rdata)
  );

  assign element = s1_zero_q ? '0 : $signed(rdata);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (p_valid_q) begin
      acc_d = sat_add(acc_q, prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q      <= '0;
      s1_valid_q <= 1'b0;
      p_valid_q  <= 1'b0;
      acc_q      <= '0;
    end else begin
      tok_q      <= tok_i;
      s1_valid_q <= tok_q.valid && (tok_q.mode == MODE_ENTRY) && active;
      p_valid_q  <= s1_valid_q;
      acc_q      <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_value_q <= $signed(tok_q.value);
    s1_zero_q  <= !in_range;
    prod_q     <= SUM_W'(s1_value_q) * SUM_W'(element);
  end

  assign tok_o = tok_q;
  assign acc_o = acc_q;

endmodule

### rtl/sparse_row_matrix_multi_vector_product_core.sv
`timescale 1ns / 1ps
// Top level: sparse row-compressed matrix times a block of dense vectors.
//
// Input stream: tuser 0 loads a vector element (column = position, vector_sel =
// vector), tuser 1 is a matrix entry (column, value), tlast marks the last entry
// of a row. Loads and entries without tlast are taken one per cycle. The item
// walks a chain of one cell per vector, one cell per cycle; each cell reads its
// element bank, multiplies and adds into its own saturating accumulator.
// On an entry with tlast, tready drops while the chain drains, then one result
// per active vector comes out in vector order, tlast on the final vector, tuser
// on the final row. tready stays low until the last result of the row is taken;
// after that the accumulators are cleared and input resumes in the next cycle.
// When the receiver stalls, the current result holds and nothing is lost.
// Reset clears the chain, the accumulators, the row counter and sets both
// registers to 1. Element banks are not cleared; load before use.
// Configuration: cfg_we_i with cfg_idx_i 0 = row count, 1 = vector count;
// write only while no row is in flight.
module sparse_row_matrix_multi_vector_product_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: column[9:0], vector_sel[12:10], value[44:13], zero pad
  input  logic [srmvp_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // tuser: mode
  input  logic                                s_axis_tuser_i,
  input  logic                                s_axis_tlast_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: row_index[9:0], vector_index[12:10], sum[76:13], zero pad
  output logic [srmvp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // tuser: last_of_matrix
  output logic                                m_axis_tuser_o,
  output logic                                m_axis_tlast_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [srmvp_pkg::CFG_W-1:0]         cfg_data_i
);
  import srmvp_pkg::*;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [VSEL_W-1:0]       out_idx_q, out_idx_d;
  logic [ROW_W-1:0]        row_cnt_q, row_cnt_d;
  logic [RC_W-1:0]         row_count_q;
  logic [VC_W-1:0]         vector_count_q;
  logic [RC_W-1:0]         act_rows;
  logic [VC_W-1:0]         nv;
  logic                    last_matrix;
  logic                    last_row_item;
  logic                    s_ready;
  logic                    m_valid;
  ctrl_t                   ctrl;
  tok_t                    in_tok;
  tok_t                    tok_link [NCELL];
  logic signed [SUM_W-1:0] acc_w [NCELL];

  assign act_rows = (row_count_q == '0) ? RC_W'(1) :
                    (row_count_q > RC_W'(MAX_ROWS)) ? RC_W'(MAX_ROWS) : row_count_q;
  assign nv       = (vector_count_q == '0) ? VC_W'(1) :
                    (vector_count_q > VC_W'(NCELL)) ? VC_W'(NCELL) : vector_count_q;

  assign last_matrix   = ((RC_W'({1'b0, row_cnt_q}) + RC_W'(1)) >= act_rows);
  assign last_row_item = ((VC_W'({1'b0, out_idx_q}) + VC_W'(1)) == nv);

  assign in_tok.valid  = s_axis_tvalid_i && s_ready;
  assign in_tok.mode   = mode_e'(s_axis_tuser_i);
  assign in_tok.column = s_axis_tdata_i[COL_W-1:0];
  assign in_tok.sel    = s_axis_tdata_i[COL_W +: VSEL_W];
  assign in_tok.value  = s_axis_tdata_i[COL_W+VSEL_W +: VAL_W];

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign tok_link[g] = in_tok;
    end
    if (g < NCELL - 1) begin : g_mid
      srmvp_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .cell_id_i(VSEL_W'(g)),
        .ctrl_i   (ctrl),
        .tok_i    (tok_link[g]),
        .tok_o    (tok_link[g+1]),
        .acc_o    (acc_w[g])
      );
    end else begin : g_tail
      srmvp_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .cell_id_i(VSEL_W'(g)),
        .ctrl_i   (ctrl),
        .tok_i    (tok_link[g]),
        .tok_o    (),
        .acc_o    (acc_w[g])
      );
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    out_idx_d  = out_idx_q;
    row_cnt_d  = row_cnt_q;
    ctrl.nv    = nv;
    ctrl.clear = 1'b0;
    s_ready    = 1'b0;
    m_valid    = 1'b0;
    unique case (state_q)
      ST_STREAM: begin
        s_ready = 1'b1;
        if (s_axis_tvalid_i && (mode_e'(s_axis_tuser_i) == MODE_ENTRY) && s_axis_tlast_i) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end
      end
      ST_DRAIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DRAIN_LAST)) begin
          state_d   = ST_EMIT;
          out_idx_d = '0;
        end
      end
      ST_EMIT: begin
        m_valid = 1'b1;
        if (m_axis_tready_i) begin
          if (last_row_item) begin
            ctrl.clear = 1'b1;
            state_d    = ST_STREAM;
            row_cnt_d  = last_matrix ? '0 : row_cnt_q + 1'b1;
          end else begin
            out_idx_d = out_idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_STREAM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_STREAM;
      cnt_q          <= '0;
      out_idx_q      <= '0;
      row_cnt_q      <= '0;
      row_count_q    <= RC_W'(1);
      vector_count_q <= VC_W'(1);
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_idx_q <= out_idx_d;
      row_cnt_q <= row_cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ROW_COUNT:    row_count_q    <= cfg_data_i[RC_W-1:0];
          CFG_VECTOR_COUNT: vector_count_q <= cfg_data_i[VC_W-1:0];
          default:          row_count_q    <= row_count_q;
        endcase
      end
    end
  end

  assign s_axis_tready_o = s_ready;
  assign m_axis_tvalid_o = m_valid;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, acc_w[out_idx_q], out_idx_q, row_cnt_q};
  assign m_axis_tlast_o  = last_row_item;
  assign m_axis_tuser_o  = last_matrix;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input open while results are pending");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> ({1'b0, out_idx_q} < nv))
    else $error("result index beyond active vectors");

  a_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("input not resumed after last result of row");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> (acc_w[0] == '0))
    else $error("accumulator not cleared after row");

endmodule
